// File: src/irpw_pkg.sv
// ----------------------------------------------------------------------------
// irpw_pkg
// Shared types and constants of the pulse-width IR byte receiver.
// ----------------------------------------------------------------------------
package irpw_pkg;

  localparam int unsigned StampW = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [StampW-1:0] OneMinRst    = 16'd34;
  localparam logic [StampW-1:0] StartMinRst  = 16'd56;
  localparam logic [StampW-1:0] StartMaxRst  = 16'd80;
  localparam logic [StampW-1:0] StopLimitRst = 16'd110;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ONE_MIN    = 3'd0,
    CFG_START_MIN  = 3'd1,
    CFG_START_MAX  = 3'd2,
    CFG_STOP_LIMIT = 3'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [StampW-1:0] one_min;
    logic [StampW-1:0] start_min;
    logic [StampW-1:0] start_max;
    logic [StampW-1:0] stop_limit;
  } thresh_t;

  typedef struct packed {
    logic             emit;
    logic [ByteW-1:0] data;
  } result_t;

endpackage

// File: src/ir_pulse_width_byte_receiver.sv
// ----------------------------------------------------------------------------
// ir_pulse_width_byte_receiver
// Decodes sensor edge events into bytes framed by start and stop pulses.
// ----------------------------------------------------------------------------
// One edge item is taken every cycle. An item is registered on entry, then
// the width subtraction and threshold compares run combinationally and update
// the frame state; a stop pulse loads the byte into the result register.
// Input stalls only when a stop pulse finds the result register still full
// and not being taken. Thresholds are written through cfg_we / cfg_index /
// cfg_wdata; the user must do so only while idle, the block does not enforce it.
module ir_pulse_width_byte_receiver (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_edge_rising,
  input  logic [irpw_pkg::StampW-1:0]     in_tick_stamp,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [irpw_pkg::ByteW-1:0]      out_data_byte,
  input  logic                            cfg_we,
  input  logic [irpw_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [irpw_pkg::StampW-1:0]     cfg_wdata
);
  import irpw_pkg::*;

  thresh_t           thresh_r;
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_rise_r;
  logic [StampW-1:0] s1_stamp_r;
  logic              s1_fire;
  logic              out_free;
  logic              in_fire;
  result_t           result;

  // threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r.one_min    <= OneMinRst;
      thresh_r.start_min  <= StartMinRst;
      thresh_r.start_max  <= StartMaxRst;
      thresh_r.stop_limit <= StopLimitRst;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ONE_MIN:    thresh_r.one_min    <= cfg_wdata;
        CFG_START_MIN:  thresh_r.start_min  <= cfg_wdata;
        CFG_START_MAX:  thresh_r.start_max  <= cfg_wdata;
        CFG_STOP_LIMIT: thresh_r.stop_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  assign s1_fire      = s1_valid_r && (!result.emit || out_free);
  assign in_ready     = !s1_valid_r || s1_fire;
  assign in_fire      = in_valid && in_ready;
  assign s1_valid_nxt = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_rise_r  <= in_edge_rising;
      s1_stamp_r <= in_tick_stamp;
    end
  end

  irpw_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_fire   (s1_fire),
    .item_rising (s1_rise_r),
    .item_stamp  (s1_stamp_r),
    .thresh      (thresh_r),
    .result      (result)
  );

  irpw_out_reg u_out_reg (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (s1_fire && result.emit),
    .load_data     (result.data),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_data_byte (out_data_byte),
    .free          (out_free)
  );

  // a held item stays in the input register
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |=> s1_valid_r && $stable(s1_stamp_r))
    else $error("input item dropped while stalled");

  // rising edges never produce a byte
  a_rise_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_rise_r |-> !result.emit)
    else $error("rising edge produced a byte");

  // an emitted byte lands in the result register
  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && result.emit |=> out_valid && (out_data_byte == $past(result.data)))
    else $error("emitted byte lost");

  // a stall can only come from a full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && result.emit && out_valid && !out_ready)
    else $error("unexpected input stall");

endmodule

// File: src/irpw_decode.sv
// ----------------------------------------------------------------------------
// irpw_decode
// Pulse width measurement, classification and frame / shift state.
// ----------------------------------------------------------------------------
module irpw_decode (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           item_fire,
  input  logic                           item_rising,
  input  logic [irpw_pkg::StampW-1:0]    item_stamp,
  input  irpw_pkg::thresh_t              thresh,
  output irpw_pkg::result_t              result
);
  import irpw_pkg::*;

  logic [StampW-1:0] rise_stamp_r, rise_stamp_nxt;
  logic              in_frame_r, in_frame_nxt;
  logic [ByteW-1:0]  shift_byte_r, shift_byte_nxt;

  logic [StampW-1:0] width;
  logic              is_start;
  logic              frame_eff;
  logic [ByteW-1:0]  byte_eff;

  assign width     = item_stamp - rise_stamp_r;
  assign is_start  = (width >= thresh.start_min) && (width <= thresh.start_max);
  assign frame_eff = in_frame_r || is_start;
  assign byte_eff  = is_start ? '0 : shift_byte_r;

  always_comb begin
    rise_stamp_nxt = rise_stamp_r;
    in_frame_nxt   = in_frame_r;
    shift_byte_nxt = shift_byte_r;
    result.emit    = 1'b0;
    result.data    = byte_eff;
    if (item_rising) begin
      rise_stamp_nxt = item_stamp;
    end else begin
      in_frame_nxt   = frame_eff;
      shift_byte_nxt = byte_eff;
      if (frame_eff) begin
        if ((width >= thresh.one_min) && (width < thresh.start_min)) begin
          shift_byte_nxt = {byte_eff[ByteW-2:0], 1'b1};
        end else if (width < thresh.one_min) begin
          shift_byte_nxt = {byte_eff[ByteW-2:0], 1'b0};
        end else if ((width > thresh.start_max) && (width < thresh.stop_limit)) begin
          in_frame_nxt = 1'b0;
          result.emit  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_stamp_r <= '0;
      in_frame_r   <= 1'b0;
      shift_byte_r <= '0;
    end else if (item_fire) begin
      rise_stamp_r <= rise_stamp_nxt;
      in_frame_r   <= in_frame_nxt;
      shift_byte_r <= shift_byte_nxt;
    end
  end

endmodule

// File: src/irpw_out_reg.sv
// ----------------------------------------------------------------------------
// irpw_out_reg
// Result register holding one byte until the downstream side takes it.
// ----------------------------------------------------------------------------
module irpw_out_reg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic [irpw_pkg::ByteW-1:0]  load_data,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [irpw_pkg::ByteW-1:0]  out_data_byte,
  output logic                        free
);
  import irpw_pkg::*;

  logic             valid_r, valid_nxt;
  logic [ByteW-1:0] data_r;

  assign free      = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid     = valid_r;
  assign out_data_byte = data_r;

endmodule
